### hw/rtl/zsi_pkg.sv
// Package for the zoom step interpolator: types, codes, constants and helpers.
// No dependencies; imported by zoom_step_interpolator_core, zsi_alu and zsi_cfg.
`default_nettype none
package zsi_pkg;

  localparam int unsigned ZSI_VIEW_SPAN_DEF = 4096;
  localparam int unsigned ZSI_SLX_W         = 11;
  localparam logic [ZSI_SLX_W-1:0] ZSI_SLX_RESET = 11'd400;
  localparam int unsigned ZSI_ADDR_W        = 3;
  localparam logic        ZSI_REG_SLX       = 1'b0;

  typedef enum logic [4:0] {
    ZSI_IDLE, ZSI_P1, ZSI_D1, ZSI_P2, ZSI_D2, ZSI_SN, ZSI_SD, ZSI_SPL,
    ZSI_DM, ZSI_DQ, ZSI_QA, ZSI_QM, ZSI_RM, ZSI_RD,
    ZSI_SQG, ZSI_SQR, ZSI_SQ1, ZSI_SQ2, ZSI_MS, ZSI_MD, ZSI_FIN
  } zsi_state_e;

  typedef enum logic {
    ZSI_OP_MUL,
    ZSI_OP_DIV
  } zsi_op_e;

  typedef struct packed {
    logic        start;
    zsi_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } zsi_alu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
    logic [63:0] rem;
  } zsi_alu_rsp_t;

  function automatic logic [63:0] zsi_mag(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // 2^k < v for positive v; shifts of 63 and above never count as below
  function automatic logic zsi_pow_below(input logic [7:0] k, input logic [63:0] v);
    logic [63:0] p;
    p = 64'd1 << k[5:0];
    return (k < 8'd63) && (p < v);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/zsi_in_if.sv
// Input channel of the zoom step interpolator: valid/ready plus one item.
// No dependencies.
`default_nettype none
interface zsi_in_if;
  logic        valid;
  logic        ready;
  logic [46:0] root_low;
  logic [46:0] root_high;
  logic [46:0] target_low;
  logic [46:0] target_high;
  logic [9:0]  step_count;

  modport source (output valid, root_low, root_high, target_low, target_high, step_count,
                  input ready);
  modport sink   (input valid, root_low, root_high, target_low, target_high, step_count,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/zsi_out_if.sv
// Output channel of the zoom step interpolator: valid/ready plus one result.
// No dependencies.
`default_nettype none
interface zsi_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_root_low;
  logic [63:0] next_root_high;
  logic        range_error;

  modport source (output valid, next_root_low, next_root_high, range_error, input ready);
  modport sink   (input valid, next_root_low, next_root_high, range_error, output ready);
endinterface
`default_nettype wire

### hw/rtl/zoom_step_interpolator_core.sv
// Zoom step interpolator top level: sequencer, operand registers, output register.
// Depends on zsi_pkg, zsi_in_if, zsi_out_if, zsi_alu and zsi_cfg.
//
// One item is taken at a time. Each multiply or divide runs as one pass on the shared
// bit-serial unit, with a start, the steps of the unit and a result. A valid target
// range costs 9 passes when no speed limiting applies and 11 to 20 when it does, plus
// sequencer steps for the square root estimate; the throughput is set by the one
// bit-serial multiply/divide unit. A non-positive target range skips the passes and
// returns with range_error set. The input is ready only while the sequencer is idle;
// a finished result waits in the output register while the next item is taken.
`default_nettype none
module zoom_step_interpolator_core #(
  parameter int unsigned VIEW_SPAN = zsi_pkg::ZSI_VIEW_SPAN_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  zsi_in_if.sink                              in_if,
  zsi_out_if.source                           out_if,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [zsi_pkg::ZSI_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  import zsi_pkg::*;

  localparam logic [63:0] View = 64'(VIEW_SPAN);
  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;

  zsi_state_e state_q, state_d;
  logic       fresh_q;

  zsi_alu_req_t alu_req;
  zsi_alu_rsp_t alu_rsp;

  logic [ZSI_SLX_W-1:0] slx;

  logic [63:0] r1_q, r1_d, r2_q, r2_d, tl_q, tl_d, range_q, range_d;
  logic [63:0] n_q, n_d, d_q, d_d, m0_q, m0_d, m1_q, m1_d;
  logic [63:0] tmp_q, tmp_d, rem_q, rem_d, rt_q, rt_d, s_q, s_d;
  logic [9:0]  steps_q, steps_d;
  logic [5:0]  e_q, e_d, t_q, t_d;
  logic        sel_q, sel_d, err_q, err_d;

  logic [63:0] out_lo_q, out_lo_d, out_hi_q, out_hi_d;
  logic        out_err_q, out_err_d, out_valid_q, out_valid_d;

  logic [63:0] in_r1, in_r2, in_tl, in_th, in_range;
  logic        in_range_pos, in_acc, out_free;
  logic [63:0] lim2, cur_m, div_a, div_b, sq, sr, mx, den;
  logic [9:0]  stp_m1;
  logic [7:0]  k4, k2;
  logic [5:0]  ee;
  logic [63:0] rt0, rtn;

  zsi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .slx_o   (slx)
  );

  zsi_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign in_r1        = {{17{in_if.root_low[46]}}, in_if.root_low};
  assign in_r2        = {{17{in_if.root_high[46]}}, in_if.root_high};
  assign in_tl        = {{17{in_if.target_low[46]}}, in_if.target_low};
  assign in_th        = {{17{in_if.target_high[46]}}, in_if.target_high};
  assign in_range     = in_th - in_tl;
  assign in_range_pos = ($signed(in_range) > 64'sd0);
  assign in_if.ready  = (state_q == ZSI_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_q || out_if.ready;

  assign lim2   = {{(63-ZSI_SLX_W){1'b0}}, slx, 1'b0};
  assign cur_m  = sel_q ? m1_q : m0_q;
  assign mx     = (zsi_mag(m0_q) > zsi_mag(m1_q)) ? zsi_mag(m0_q) : zsi_mag(m1_q);
  assign stp_m1 = (steps_q == 10'd0) ? 10'd0 : (steps_q - 10'd1);
  assign den    = {48'd0, stp_m1, 6'd0} + s_q;
  assign k4     = {e_q, 2'b00};
  assign k2     = {1'b0, e_q + t_q, 1'b0};
  assign ee     = (e_q > 6'd62) ? 6'd62 : e_q;
  assign rt0    = 64'd1 << ee;
  assign rtn    = (rt0 + (range_q >> ee)) >> 1;

  // signed division operands per state
  always_comb begin
    div_a = range_q;
    div_b = 64'd1;
    case (state_q)
      ZSI_D1, ZSI_D2: begin div_a = tmp_q; div_b = range_q; end
      ZSI_SPL:        begin div_a = MaxPos; div_b = n_q; end
      ZSI_DQ:         begin div_a = tmp_q; div_b = d_q; end
      ZSI_QA:         begin div_a = cur_m; div_b = d_q; end
      ZSI_RD:         begin div_a = rem_q; div_b = d_q; end
      ZSI_SQ2:        begin div_a = range_q; div_b = rt_q; end
      ZSI_MD:         begin div_a = tmp_q; div_b = den; end
      default:        begin div_a = range_q; div_b = 64'd1; end
    endcase
  end

  always_comb begin
    if (div_b == 64'd0) begin
      sq = '0;
      sr = '0;
    end else begin
      sq = (div_a[63] ^ div_b[63]) ? (64'd0 - alu_rsp.res) : alu_rsp.res;
      sr = div_a[63] ? (64'd0 - alu_rsp.rem) : alu_rsp.rem;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ZSI_IDLE: if (in_acc) state_d = in_range_pos ? ZSI_P1 : ZSI_FIN;
      ZSI_P1:   if (alu_rsp.done) state_d = ZSI_D1;
      ZSI_D1:   if (alu_rsp.done) state_d = ZSI_P2;
      ZSI_P2:   if (alu_rsp.done) state_d = ZSI_D2;
      ZSI_D2: begin
        if (alu_rsp.done) state_d = ($signed(range_q) < $signed(lim2)) ? ZSI_SN : ZSI_SQG;
      end
      ZSI_SN:   if (alu_rsp.done) state_d = ZSI_SD;
      ZSI_SD: begin
        if (alu_rsp.done) begin
          if (alu_rsp.res == 64'd0) state_d = ZSI_SQG;
          else if (n_q == 64'd0)    state_d = ZSI_DM;
          else if (n_q[63])         state_d = ZSI_QA;
          else                      state_d = ZSI_SPL;
        end
      end
      ZSI_SPL:  if (alu_rsp.done) state_d = (mx > alu_rsp.res) ? ZSI_QA : ZSI_DM;
      ZSI_DM:   if (alu_rsp.done) state_d = ZSI_DQ;
      ZSI_DQ:   if (alu_rsp.done) state_d = sel_q ? ZSI_SQG : ZSI_DM;
      ZSI_QA:   if (alu_rsp.done) state_d = ZSI_QM;
      ZSI_QM:   if (alu_rsp.done) state_d = ZSI_RM;
      ZSI_RM:   if (alu_rsp.done) state_d = ZSI_RD;
      ZSI_RD:   if (alu_rsp.done) state_d = sel_q ? ZSI_SQG : ZSI_QA;
      ZSI_SQG:  if (!zsi_pow_below(k4, range_q)) state_d = ZSI_SQR;
      ZSI_SQR:  if (t_q == 6'd0) state_d = ZSI_SQ1;
      ZSI_SQ1:  state_d = ZSI_SQ2;
      ZSI_SQ2:  if (alu_rsp.done) state_d = ZSI_MS;
      ZSI_MS:   if (alu_rsp.done) state_d = ZSI_MD;
      ZSI_MD:   if (alu_rsp.done) state_d = sel_q ? ZSI_FIN : ZSI_MS;
      ZSI_FIN:  if (out_free) state_d = ZSI_IDLE;
      default:  state_d = ZSI_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    r1_d = r1_q; r2_d = r2_q; tl_d = tl_q; range_d = range_q;
    n_d = n_q; d_d = d_q; m0_d = m0_q; m1_d = m1_q;
    tmp_d = tmp_q; rem_d = rem_q; rt_d = rt_q; s_d = s_q;
    steps_d = steps_q; e_d = e_q; t_d = t_q; sel_d = sel_q; err_d = err_q;
    out_lo_d = out_lo_q; out_hi_d = out_hi_q; out_err_d = out_err_q;
    out_valid_d = out_valid_q && !out_if.ready;
    alu_req.start = fresh_q;
    alu_req.op    = ZSI_OP_DIV;
    alu_req.a     = zsi_mag(div_a);
    alu_req.b     = zsi_mag(div_b);

    unique case (state_q)
      ZSI_IDLE: begin
        alu_req.start = 1'b0;
        if (in_acc) begin
          r1_d = in_r1; r2_d = in_r2; tl_d = in_tl; range_d = in_range;
          steps_d = in_if.step_count;
          m0_d = '0; m1_d = '0; sel_d = 1'b0; e_d = 6'd1;
          err_d = !in_range_pos;
        end
      end
      ZSI_P1: begin
        alu_req.op = ZSI_OP_MUL; alu_req.a = View; alu_req.b = r1_q - tl_q;
        if (alu_rsp.done) tmp_d = alu_rsp.res;
      end
      ZSI_D1: if (alu_rsp.done) m0_d = sq - r1_q;
      ZSI_P2: begin
        alu_req.op = ZSI_OP_MUL; alu_req.a = View; alu_req.b = r2_q - tl_q;
        if (alu_rsp.done) tmp_d = alu_rsp.res;
      end
      ZSI_D2: if (alu_rsp.done) m1_d = sq - r2_q;
      ZSI_SN: begin
        alu_req.op = ZSI_OP_MUL; alu_req.a = range_q; alu_req.b = View - lim2;
        if (alu_rsp.done) n_d = alu_rsp.res;
      end
      ZSI_SD: begin
        alu_req.op = ZSI_OP_MUL; alu_req.a = View - range_q; alu_req.b = lim2;
        if (alu_rsp.done) begin
          d_d = alu_rsp.res;
          range_d = lim2;
        end
      end
      ZSI_SPL: ;
      ZSI_DM: begin
        alu_req.op = ZSI_OP_MUL; alu_req.a = cur_m; alu_req.b = n_q;
        if (alu_rsp.done) tmp_d = alu_rsp.res;
      end
      ZSI_DQ: begin
        if (alu_rsp.done) begin
          if (sel_q) m1_d = sq; else m0_d = sq;
          sel_d = !sel_q;
        end
      end
      ZSI_QA: begin
        if (alu_rsp.done) begin
          tmp_d = sq;
          rem_d = sr;
        end
      end
      ZSI_QM: begin
        alu_req.op = ZSI_OP_MUL; alu_req.a = tmp_q; alu_req.b = n_q;
        if (alu_rsp.done) tmp_d = alu_rsp.res;
      end
      ZSI_RM: begin
        alu_req.op = ZSI_OP_MUL; alu_req.a = rem_q; alu_req.b = n_q;
        if (alu_rsp.done) rem_d = alu_rsp.res;
      end
      ZSI_RD: begin
        if (alu_rsp.done) begin
          if (sel_q) m1_d = tmp_q + sq; else m0_d = tmp_q + sq;
          sel_d = !sel_q;
        end
      end
      ZSI_SQG: begin
        alu_req.start = 1'b0;
        // grow the exponent estimate, then hand the refinement half of it
        if (zsi_pow_below(k4, range_q)) e_d = {e_q[4:0], 1'b0};
        else t_d = {1'b0, e_q[5:1]};
      end
      ZSI_SQR: begin
        alu_req.start = 1'b0;
        if (t_q != 6'd0) begin
          if (zsi_pow_below(k2, range_q)) e_d = e_q + t_q;
          t_d = {1'b0, t_q[5:1]};
        end
      end
      ZSI_SQ1: begin
        alu_req.start = 1'b0;
        rt_d = (rtn == 64'd0) ? 64'd1 : rtn;
      end
      ZSI_SQ2: if (alu_rsp.done) s_d = (rt_q + alu_rsp.res) >> 1;
      ZSI_MS: begin
        alu_req.op = ZSI_OP_MUL; alu_req.a = cur_m; alu_req.b = s_q;
        if (alu_rsp.done) tmp_d = alu_rsp.res;
      end
      ZSI_MD: begin
        if (alu_rsp.done) begin
          if (sel_q) m1_d = sq; else m0_d = sq;
          sel_d = !sel_q;
        end
      end
      ZSI_FIN: begin
        alu_req.start = 1'b0;
        if (out_free) begin
          out_lo_d    = r1_q + m0_q;
          out_hi_d    = r2_q + m1_q;
          out_err_d   = err_q;
          out_valid_d = 1'b1;
        end
      end
      default: alu_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ZSI_IDLE;
      fresh_q     <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      fresh_q     <= (state_d != state_q);
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q <= r1_d; r2_q <= r2_d; tl_q <= tl_d; range_q <= range_d;
    n_q <= n_d; d_q <= d_d; m0_q <= m0_d; m1_q <= m1_d;
    tmp_q <= tmp_d; rem_q <= rem_d; rt_q <= rt_d; s_q <= s_d;
    steps_q <= steps_d; e_q <= e_d; t_q <= t_d; err_q <= err_d;
    out_lo_q <= out_lo_d; out_hi_q <= out_hi_d; out_err_q <= out_err_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.next_root_low  = out_lo_q;
  assign out_if.next_root_high = out_hi_q;
  assign out_if.range_error    = out_err_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_rsp.busy) else $error("unit started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ZSI_IDLE) else $error("item accepted but sequencer idle");

  a_done_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q != ZSI_IDLE && state_q != ZSI_FIN))
    else $error("unit result with no consumer");

endmodule
`default_nettype wire

### hw/rtl/zsi_alu.sv
// Shared bit-serial unit: 64-bit wrapping multiply and unsigned divide.
// Depends on zsi_pkg.
`default_nettype none
module zsi_alu (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire zsi_pkg::zsi_alu_req_t req_i,
  output zsi_pkg::zsi_alu_rsp_t      rsp_o
);
  import zsi_pkg::*;

  logic [63:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  zsi_op_e     op_q, op_d;
  logic [64:0] sh;
  logic [64:0] diff;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    sh     = {x_q, y_q[63]};
    diff   = sh - {1'b0, z_q};
    if (!busy_q && req_i.start) begin
      x_d    = '0;
      y_d    = req_i.a;
      z_d    = req_i.b;
      op_d   = req_i.op;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (op_q == ZSI_OP_MUL) begin
        if (z_q[0]) x_d = x_q + y_q;
        y_d = {y_q[62:0], 1'b0};
        z_d = {1'b0, z_q[63:1]};
      end else begin
        // restoring step: shift in the next dividend bit, subtract if it fits
        if (!diff[64]) begin
          x_d = diff[63:0];
          y_d = {y_q[62:0], 1'b1};
        end else begin
          x_d = sh[63:0];
          y_d = {y_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ZSI_OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == ZSI_OP_MUL) ? x_q : y_q;
  assign rsp_o.rem  = x_q;

endmodule
`default_nettype wire

### hw/rtl/zsi_cfg.sv
// APB-style register port holding speed_limit_x.
// Depends on zsi_pkg.
`default_nettype none
module zsi_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [zsi_pkg::ZSI_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output logic      [zsi_pkg::ZSI_SLX_W-1:0]    slx_o
);
  import zsi_pkg::*;

  logic [ZSI_SLX_W-1:0] slx_q, slx_d;
  logic                 hit;

  assign hit    = (paddr[2] == ZSI_REG_SLX);
  assign pready = 1'b1;

  always_comb begin
    slx_d = slx_q;
    if (psel && penable && pwrite && hit) slx_d = pwdata[ZSI_SLX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slx_q <= ZSI_SLX_RESET;
    end else begin
      slx_q <= slx_d;
    end
  end

  assign prdata = hit ? {{(32-ZSI_SLX_W){1'b0}}, slx_q} : 32'd0;
  assign slx_o  = slx_q;

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking bench for zoom_step_interpolator_core: random and directed zoom steps,
// predicted in-bench and compared beat by beat. Depends on zsi_pkg, zsi_in_if, zsi_out_if, zoom_step_interpolator_core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import zsi_pkg::*;

  localparam longint unsigned VIEW = 4096;
  localparam logic [63:0] SIGN = 64'h8000000000000000;
  localparam int MAX_ITEMS = 1024;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [46:0] rl, rh, tl, th;
    logic [9:0]  steps;
  } zoom_req_t;

  typedef struct packed {
    logic [63:0] nl, nh;
    logic        err;
  } zoom_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ZSI_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  zsi_in_if  in_ch();
  zsi_out_if out_ch();

  zoom_step_interpolator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_ch.sink), .out_if(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  // items and predicted results, indexed in send order
  zoom_req_t req_mem [MAX_ITEMS];
  zoom_res_t exp_mem [MAX_ITEMS];
  int n_pushed = 0;
  int n_sent;
  int n_checked;
  logic [10:0] speed_lim = ZSI_SLX_RESET;
  int src_idle_pct = 0, snk_idle_pct = 0;
  bit hold_go = 0;
  bit holding = 0;
  int mismatches = 0, beats_out = 0, err_beats = 0;
  bit stim_done = 0;

  function automatic logic [63:0] sx47(logic [46:0] v);
    return {{17{v[46]}}, v};
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic [63:0] sdiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    if (b == 0) return 0;
    q = mag64(a) / mag64(b);
    return ((a ^ b) & SIGN) != 0 ? 64'd0 - q : q;
  endfunction

  function automatic logic [63:0] srem64(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    if (b == 0) return 0;
    r = mag64(a) % mag64(b);
    return a[63] ? 64'd0 - r : r;
  endfunction

  function automatic bit pow_lt(logic [63:0] k, logic [63:0] v);
    if (k >= 63) return 0;
    return (64'd1 << k) < v;
  endfunction

  function automatic logic [63:0] root_estimate(logic [63:0] v);
    logic [63:0] e, t, rt;
    e = 1;
    while (pow_lt(4 * e, v)) e = e * 2;
    for (t = e / 2; t != 0; t = t / 2)
      if (pow_lt(2 * (e + t), v)) e = e + t;
    if (e > 62) e = 62;
    rt = 64'd1 << e;
    rt = (rt + v / rt) / 2;
    if (rt == 0) rt = 1;
    return (rt + v / rt) / 2;
  endfunction

  function automatic logic [63:0] scaled_move(logic [63:0] m, n, d, bit split);
    if (split) return sdiv64(m, d) * n + sdiv64(srem64(m, d) * n, d);
    return sdiv64(m * n, d);
  endfunction

  function automatic zoom_res_t zoom_step(zoom_req_t q);
    zoom_res_t res;
    logic [63:0] r1, r2, tl, range, m1, m2, lim2, n, d, s, den, mx, steps;
    bit split;
    r1 = sx47(q.rl); r2 = sx47(q.rh); tl = sx47(q.tl);
    range = sx47(q.th) - tl;
    if ($signed(range) <= 0) begin
      res.nl = r1; res.nh = r2; res.err = 1'b1;
      return res;
    end
    m1 = sdiv64(VIEW * (r1 - tl), range) - r1;
    m2 = sdiv64(VIEW * (r2 - tl), range) - r2;
    lim2 = 2 * {53'd0, speed_lim};
    if ($signed(range) < $signed(lim2)) begin
      n = range * (VIEW - lim2);
      d = (VIEW - range) * lim2;
      if (d != 0) begin
        mx = mag64(m1) > mag64(m2) ? mag64(m1) : mag64(m2);
        if (n == 0) split = 0;
        else if (n[63]) split = 1;
        else split = mx > (SIGN - 1) / n;
        m1 = scaled_move(m1, n, d, split);
        m2 = scaled_move(m2, n, d, split);
      end
      range = lim2;
    end
    steps = (q.steps == 0) ? 64'd1 : {54'd0, q.steps};
    s = root_estimate(range);
    den = 64 * (steps - 1) + s;
    res.nl = r1 + sdiv64(m1 * s, den);
    res.nh = r2 + sdiv64(m2 * s, den);
    res.err = 1'b0;
    return res;
  endfunction

  function automatic logic [46:0] rnd47();
    logic [46:0] v;
    v = 47'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: return v;
      1: return {{27{v[19]}}, v[19:0]};
      2: return {{35{v[11]}}, v[11:0]};
      default: return {{15{v[31]}}, v[31:0]};
    endcase
  endfunction

  function automatic zoom_req_t rnd_req();
    zoom_req_t q;
    logic [46:0] span;
    q.rl = rnd47(); q.rh = rnd47(); q.tl = rnd47();
    span = $urandom_range(0, 1) ? 47'($urandom_range(1, 5000)) : 47'($urandom);
    q.th = ($urandom_range(0, 9) == 0) ? rnd47() : q.tl + span;
    q.steps = $urandom_range(0, 7) == 0 ? 10'($urandom) : 10'($urandom_range(1, 64));
    return q;
  endfunction

  task automatic add_req(zoom_req_t q);
    if (n_pushed < MAX_ITEMS) begin
      req_mem[n_pushed] = q;
      exp_mem[n_pushed] = zoom_step(q);
      n_pushed++;
    end
  endtask

  task automatic apb_write(logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ZSI_ADDR_W'(ZSI_REG_SLX); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    speed_lim = value[10:0];
  endtask

  task automatic drain();
    while (n_checked < n_pushed) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // driver: hold the beat until accepted, then advance to the next item
  always @(posedge clk_i) begin : drv
    int head;
    zoom_req_t q;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.root_low <= '0; in_ch.root_high <= '0;
      in_ch.target_low <= '0; in_ch.target_high <= '0;
      in_ch.step_count <= '0;
      n_sent <= 0;
    end else begin
      head = n_sent + ((in_ch.valid && in_ch.ready) ? 1 : 0);
      if (!in_ch.valid || in_ch.ready) begin
        if (head < n_pushed && $urandom_range(0, 99) >= src_idle_pct) begin
          q = req_mem[head];
          in_ch.valid <= 1'b1;
          in_ch.root_low <= q.rl; in_ch.root_high <= q.rh;
          in_ch.target_low <= q.tl; in_ch.target_high <= q.th;
          in_ch.step_count <= q.steps;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      n_sent <= head;
    end
  end

  // long receiver stall, counted here
  initial begin : hold_proc
    wait (hold_go);
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  // monitor and sink
  always @(posedge clk_i) begin : mon
    zoom_res_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      n_checked <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_out++;
        if (out_ch.range_error) err_beats++;
        if (n_checked >= n_pushed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: got %h %h %b", out_ch.next_root_low,
                     out_ch.next_root_high, out_ch.range_error);
        end else begin
          want = exp_mem[n_checked];
          n_checked <= n_checked + 1;
          if (want.nl !== out_ch.next_root_low || want.nh !== out_ch.next_root_high
              || want.err !== out_ch.range_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %b got %h %h %b", want.nl, want.nh, want.err,
                       out_ch.next_root_low, out_ch.next_root_high, out_ch.range_error);
          end
        end
      end
      if (holding) out_ch.ready <= 1'b0;
      else out_ch.ready <= $urandom_range(0, 99) >= snk_idle_pct;
    end
  end

  initial begin
    zoom_req_t q;
    logic [10:0] lims[4];
    lims = '{11'd1, 11'd2047, 11'd400, 11'd1000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    q = '{47'h3FFFFFFFFFFF, 47'h400000000000, 47'd0, 47'd100, 10'd1}; add_req(q);
    q = '{47'd5, 47'd9, 47'd100, 47'd100, 10'd3}; add_req(q);
    q = '{47'd5, 47'd9, 47'd200, 47'd100, 10'd3}; add_req(q);
    q = '{47'h400000000000, 47'h3FFFFFFFFFFF, 47'h400000000000, 47'h3FFFFFFFFFFF, 10'd1023};
    add_req(q);
    q = '{47'd0, 47'd4096, 47'd0, 47'd4096, 10'd1}; add_req(q);
    q = '{47'd10, 47'd20, 47'd0, 47'd1, 10'd0}; add_req(q);
    q = '{47'h3FFFFFFFFFFF, 47'h400000000000, 47'd0, 47'd3, 10'd2}; add_req(q);
    q = '{47'd100, 47'd900, 47'd300, 47'd700, 10'd10}; add_req(q);
    q = '{47'h400000000000, 47'd0, 47'h7FFFFFFFFFFF, 47'd0, 10'd1}; add_req(q);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      apb_write({21'd0, lims[ph]});
      if (ph == 1) begin
        q = '{47'd0, 47'd4096, 47'd0, 47'd4096, 10'd5}; add_req(q);
        q = '{47'h3FFFFFFFFFFF, 47'h400000000000, 47'd0, 47'd2, 10'd1}; add_req(q);
      end
      src_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 64 : 0;
      snk_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 6 : 0;
      if (ph == 3) hold_go = 1;
      for (int i = 0; i < 135; i++) add_req(rnd_req());
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    $display("covered %0d result beats (%0d range errors) at the reset speed limit",
             beats_out, err_beats);
    $display("and four written limits, with idling on both sides and one long sink stall");
    if (mismatches == 0 && n_checked == n_pushed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("status: fail");
    $finish;
  end
endmodule
